// ----- rtl/tsr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tsr_pkg;

    localparam int TIME_W = 26;
    localparam int LEN_W  = 16;
    localparam int JOB_W  = 10;
    localparam int PROD_W = TIME_W + JOB_W;
    // period * job_index + offset
    localparam int NUM_W  = PROD_W + 1;
    localparam int CNT_W  = $clog2(NUM_W);

    localparam logic [TIME_W-1:0] TIME_MAX       = '1;
    localparam logic [LEN_W-1:0]  RESET_SLOT_LEN = 16'd1000;

    localparam logic ACT_CLEAR   = 1'b0;
    localparam logic ACT_RESERVE = 1'b1;

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_MUL  = 5'b00010,
        F_ADD  = 5'b00100,
        F_DIV  = 5'b01000,
        F_PUSH = 5'b10000
    } t_front_state;

    typedef enum logic [5:0] {
        B_SWEEP = 6'b000001,
        B_IDLE  = 6'b000010,
        B_RD    = 6'b000100,
        B_DATA  = 6'b001000,
        B_USE   = 6'b010000,
        B_OUT   = 6'b100000
    } t_back_state;

    typedef struct packed {
        logic init_busy;
    } t_back_status;

endpackage

`default_nettype wire

// ----- rtl/tsr_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tsr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/tsr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tsr_front #(
    parameter int NUM_SLOTS = 1024,
    parameter int QW        = 80
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [tsr_pkg::LEN_W-1:0]    i_slot_length,
    input  tsr_pkg::t_back_status        i_status,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_action,
    input  logic [tsr_pkg::TIME_W-1:0]   i_period,
    input  logic [tsr_pkg::TIME_W-1:0]   i_offset,
    input  logic [tsr_pkg::JOB_W-1:0]    i_job_index,
    input  logic [tsr_pkg::TIME_W-1:0]   i_exec_time,
    input  logic                         i_q_full,
    output logic                         o_push,
    output logic [QW-1:0]                o_q_data
);

    import tsr_pkg::*;

    localparam int IW = $clog2(NUM_SLOTS);
    localparam int TW = IW + LEN_W;
    localparam logic [NUM_W-1:0] NUM_SLOTS_W = NUM_W'(NUM_SLOTS);
    localparam logic [CNT_W-1:0] LAST_STEP   = CNT_W'(NUM_W - 1);

    t_front_state       r_state, n_state;
    logic               r_action, n_action;
    logic               r_lenz, n_lenz;
    logic [TIME_W-1:0]  r_period, n_period;
    logic [TIME_W-1:0]  r_offset, n_offset;
    logic [JOB_W-1:0]   r_job, n_job;
    logic [TIME_W-1:0]  r_exec, n_exec;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic [NUM_W-1:0]   r_num, n_num;
    logic [NUM_W-1:0]   r_shift, n_shift;
    logic [LEN_W-1:0]   r_rem, n_rem;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    logic               accept;
    logic [LEN_W:0]     trial;
    logic               ge;
    logic               past;
    logic [IW-1:0]      rel_idx;
    logic [TW-1:0]      rel_base;

    assign o_in_stall = (r_state != F_IDLE) || i_status.init_busy;
    assign accept     = i_in_valid && !o_in_stall;

    // restoring divide, one quotient bit per step
    assign trial = {r_rem, r_shift[NUM_W-1]};
    assign ge    = trial >= {1'b0, i_slot_length};

    // quotient ends up in r_shift; slot base = numerator - remainder
    assign past     = r_shift >= NUM_SLOTS_W;
    assign rel_idx  = r_shift[IW-1:0];
    assign rel_base = TW'(r_num - NUM_W'(r_rem));

    assign o_push   = (r_state == F_PUSH) && !i_q_full;
    assign o_q_data = {r_action, r_lenz, past, rel_idx, rel_base, r_exec};

    always_comb begin
        n_state  = r_state;
        n_action = r_action;
        n_lenz   = r_lenz;
        n_period = r_period;
        n_offset = r_offset;
        n_job    = r_job;
        n_exec   = r_exec;
        n_prod   = r_prod;
        n_num    = r_num;
        n_shift  = r_shift;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_action = i_action;
                    n_lenz   = (i_slot_length == '0);
                    n_period = i_period;
                    n_offset = i_offset;
                    n_job    = i_job_index;
                    n_exec   = i_exec_time;
                    if (i_action == ACT_CLEAR || i_slot_length == '0) begin
                        n_state = F_PUSH;
                    end else begin
                        n_state = F_MUL;
                    end
                end
            end
            F_MUL: begin
                n_prod  = PROD_W'(r_period) * PROD_W'(r_job);
                n_state = F_ADD;
            end
            F_ADD: begin
                n_num   = NUM_W'(r_prod) + NUM_W'(r_offset);
                n_shift = NUM_W'(r_prod) + NUM_W'(r_offset);
                n_rem   = '0;
                n_cnt   = '0;
                n_state = F_DIV;
            end
            F_DIV: begin
                n_rem   = ge ? LEN_W'(trial - {1'b0, i_slot_length}) : trial[LEN_W-1:0];
                n_shift = {r_shift[NUM_W-2:0], ge};
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_lenz   <= n_lenz;
        r_period <= n_period;
        r_offset <= n_offset;
        r_job    <= n_job;
        r_exec   <= n_exec;
        r_prod   <= n_prod;
        r_num    <= n_num;
        r_shift  <= n_shift;
        r_rem    <= n_rem;
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != F_IDLE))
        else $error("front took a word but stayed idle");

    a_div_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_DIV && r_cnt == LAST_STEP) |=> (r_state == F_PUSH))
        else $error("divider finished without queueing the word");

endmodule

`default_nettype wire

// ----- rtl/tsr_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tsr_queue #(
    parameter int W = 80
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_data [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_data[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != 2'd0))
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- rtl/tsr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tsr_back #(
    parameter int NUM_SLOTS = 1024,
    parameter int QW        = 80
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [tsr_pkg::LEN_W-1:0]    i_slot_length,
    output tsr_pkg::t_back_status        o_status,
    input  logic                         i_q_valid,
    input  logic [QW-1:0]                i_q_data,
    output logic                         o_q_pop,
    output logic                         o_ram_we,
    output logic [$clog2(NUM_SLOTS)-1:0] o_ram_waddr,
    output logic [tsr_pkg::LEN_W-1:0]    o_ram_wdata,
    output logic [$clog2(NUM_SLOTS)-1:0] o_ram_raddr,
    input  logic [tsr_pkg::LEN_W-1:0]    i_ram_rdata,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [tsr_pkg::TIME_W-1:0]   o_start_time,
    output logic [tsr_pkg::TIME_W-1:0]   o_end_time,
    output logic                         o_overflow
);

    import tsr_pkg::*;

    localparam int IW    = $clog2(NUM_SLOTS);
    localparam int TW    = IW + LEN_W;
    localparam int RES_W = ((TW > TIME_W) ? TW : TIME_W) + 1;
    localparam logic [IW-1:0]    LAST_IDX = IW'(NUM_SLOTS - 1);
    localparam logic [TW-1:0]    NS_T     = TW'(NUM_SLOTS);
    localparam logic [RES_W-1:0] TMAX_R   = RES_W'(TIME_MAX);

    function automatic logic [TIME_W-1:0] clamp_t(input logic [RES_W-1:0] t);
        return (t > TMAX_R) ? TIME_MAX : t[TIME_W-1:0];
    endfunction

    logic               q_action, q_lenz, q_past;
    logic [IW-1:0]      q_idx;
    logic [TW-1:0]      q_base;
    logic [TIME_W-1:0]  q_exec;

    t_back_state        r_state, n_state;
    logic               r_init, n_init;
    logic               r_clr, n_clr;
    logic [IW-1:0]      r_idx, n_idx;
    logic [LEN_W-1:0]   r_fill, n_fill;
    logic [TW-1:0]      r_base, n_base;
    logic [TW-1:0]      r_pos, n_pos;
    logic [TW-1:0]      r_start, n_start;
    logic               r_consume, n_consume;
    logic [TIME_W-1:0]  r_rem, n_rem;
    logic [LEN_W-1:0]   r_free, n_free;
    logic [RES_W-1:0]   r_res_start, n_res_start;
    logic [RES_W-1:0]   r_res_end, n_res_end;
    logic               r_res_ovf, n_res_ovf;
    logic [TW-1:0]      r_tl_end;
    logic               r_ovld;
    logic [TIME_W-1:0]  r_ostart, r_oend;
    logic               r_oovf;

    logic [LEN_W-1:0]   used;
    logic [TW-1:0]      st;
    logic               load;

    assign {q_action, q_lenz, q_past, q_idx, q_base, q_exec} = i_q_data;

    assign o_status.init_busy = r_init;

    // time already taken in the slot just read; free above length counts as none
    assign used = (i_ram_rdata >= i_slot_length) ? '0 : i_slot_length - i_ram_rdata;
    assign st   = r_consume ? r_start : r_pos;
    assign load = (r_state == B_OUT) && (!r_ovld || !i_out_stall);

    assign o_ram_raddr = r_idx;
    assign o_ram_waddr = r_idx;

    always_comb begin
        n_state     = r_state;
        n_init      = r_init;
        n_clr       = r_clr;
        n_idx       = r_idx;
        n_fill      = r_fill;
        n_base      = r_base;
        n_pos       = r_pos;
        n_start     = r_start;
        n_consume   = r_consume;
        n_rem       = r_rem;
        n_free      = r_free;
        n_res_start = r_res_start;
        n_res_end   = r_res_end;
        n_res_ovf   = r_res_ovf;
        o_q_pop     = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_wdata = r_fill;
        case (r_state)
            B_SWEEP: begin
                o_ram_we = 1'b1;
                n_idx    = r_idx + 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_init      = 1'b0;
                    n_res_start = '0;
                    n_res_end   = '0;
                    n_res_ovf   = 1'b0;
                    n_state     = r_clr ? B_OUT : B_IDLE;
                end
            end
            B_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (q_action == ACT_CLEAR) begin
                        n_fill  = i_slot_length;
                        n_idx   = '0;
                        n_clr   = 1'b1;
                        n_state = B_SWEEP;
                    end else if (q_lenz) begin
                        n_res_start = '0;
                        n_res_end   = '0;
                        n_res_ovf   = 1'b1;
                        n_state     = B_OUT;
                    end else if (q_past) begin
                        n_res_start = RES_W'(r_tl_end);
                        n_res_end   = RES_W'(r_tl_end);
                        n_res_ovf   = 1'b1;
                        n_state     = B_OUT;
                    end else begin
                        n_idx     = q_idx;
                        n_base    = q_base;
                        n_rem     = q_exec;
                        n_consume = 1'b0;
                        n_state   = B_RD;
                    end
                end
            end
            B_RD: begin
                n_state = B_DATA;
            end
            B_DATA: begin
                n_free = i_ram_rdata;
                n_pos  = r_base + TW'(used);
                if (!r_consume && i_ram_rdata == '0) begin
                    // full slot before the start: skip it
                    if (r_idx == LAST_IDX) begin
                        n_res_start = RES_W'(r_tl_end);
                        n_res_end   = RES_W'(r_tl_end);
                        n_res_ovf   = 1'b1;
                        n_state     = B_OUT;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_base  = r_base + TW'(i_slot_length);
                        n_state = B_RD;
                    end
                end else begin
                    n_state = B_USE;
                end
            end
            B_USE: begin
                n_start     = st;
                n_consume   = 1'b1;
                n_res_start = RES_W'(st);
                n_res_ovf   = 1'b0;
                if (r_rem == '0) begin
                    n_res_end = RES_W'(st);
                    n_state   = B_OUT;
                end else if (TIME_W'(r_free) < r_rem) begin
                    o_ram_we    = 1'b1;
                    o_ram_wdata = '0;
                    n_rem       = r_rem - TIME_W'(r_free);
                    if (r_idx == LAST_IDX) begin
                        n_res_end = RES_W'(r_tl_end);
                        n_res_ovf = 1'b1;
                        n_state   = B_OUT;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_base  = r_base + TW'(i_slot_length);
                        n_state = B_RD;
                    end
                end else begin
                    o_ram_we    = 1'b1;
                    o_ram_wdata = r_free - r_rem[LEN_W-1:0];
                    n_res_end   = RES_W'(r_pos) + RES_W'(r_rem);
                    n_state     = B_OUT;
                end
            end
            B_OUT: begin
                if (load) begin
                    n_clr   = 1'b0;
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_SWEEP;
            r_init  <= 1'b1;
            r_clr   <= 1'b0;
            r_idx   <= '0;
            r_fill  <= RESET_SLOT_LEN;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_clr   <= n_clr;
            r_idx   <= n_idx;
            r_fill  <= n_fill;
            if (load) begin
                r_ovld <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_base      <= n_base;
        r_pos       <= n_pos;
        r_start     <= n_start;
        r_consume   <= n_consume;
        r_rem       <= n_rem;
        r_free      <= n_free;
        r_res_start <= n_res_start;
        r_res_end   <= n_res_end;
        r_res_ovf   <= n_res_ovf;
        r_tl_end    <= NS_T * TW'(i_slot_length);
        if (load) begin
            r_ostart <= clamp_t(r_res_start);
            r_oend   <= clamp_t(r_res_end);
            r_oovf   <= r_res_ovf || (r_res_start > TMAX_R) || (r_res_end > TMAX_R);
        end
    end

    assign o_out_valid  = r_ovld;
    assign o_start_time = r_ostart;
    assign o_end_time   = r_oend;
    assign o_overflow   = r_oovf;

    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DATA) |-> ($past(r_state) == B_RD))
        else $error("slot data used without a read the cycle before");

    a_ram_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we |-> (r_state == B_SWEEP || r_state == B_USE))
        else $error("slot table written outside sweep or consume");

endmodule

`default_nettype wire

// ----- rtl/timeline_slot_reserver.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Slot timeline reserver. A reserve word computes its release slot
// (period * job_index + offset) / slot_length, skips full slots, and books
// exec_time from there on, returning start and end times; a clear word refills
// every slot with the current slot_length and answers zeros. A front stage
// takes words and works out the release slot with a radix-2 divider: a reserve
// word passes through capture, multiply, add, 37 divide steps and hand-off
// there, a clear or zero-length word through capture and hand-off only. A
// two-entry queue feeds the back stage, which walks the slot table (one read
// and one write port): a skipped full slot takes a read and a data step, a
// booked slot a read, a data and a use step, plus an idle and an output step
// per word; a zero-length or past-the-end word skips the walk. A clear word
// sweeps every slot. After reset the back stage sweeps the table, filling
// every slot with 1000; no word is taken meanwhile, while slot_length writes
// are taken as ever. The result sits in an output register so the front keeps
// taking words while a result waits, until the queue is full.
module timeline_slot_reserver #(
    parameter int NUM_SLOTS = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [tsr_pkg::LEN_W-1:0]    i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_action,
    input  logic [tsr_pkg::TIME_W-1:0]   i_period,
    input  logic [tsr_pkg::TIME_W-1:0]   i_offset,
    input  logic [tsr_pkg::JOB_W-1:0]    i_job_index,
    input  logic [tsr_pkg::TIME_W-1:0]   i_exec_time,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [tsr_pkg::TIME_W-1:0]   o_start_time,
    output logic [tsr_pkg::TIME_W-1:0]   o_end_time,
    output logic                         o_overflow
);

    import tsr_pkg::*;

    localparam int IW = $clog2(NUM_SLOTS);
    localparam int TW = IW + LEN_W;
    localparam int QW = 3 + IW + TW + TIME_W;

    logic [LEN_W-1:0] r_slot_length;
    t_back_status     status;
    logic             q_push, q_full, q_pop, q_valid;
    logic [QW-1:0]    q_wdata, q_rdata;
    logic             ram_we;
    logic [IW-1:0]    ram_waddr, ram_raddr;
    logic [LEN_W-1:0] ram_wdata, ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_length <= RESET_SLOT_LEN;
        end else if (i_cfg_we) begin
            r_slot_length <= i_cfg_data;
        end
    end

    tsr_front #(
        .NUM_SLOTS (NUM_SLOTS),
        .QW        (QW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_slot_length (r_slot_length),
        .i_status      (status),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_period      (i_period),
        .i_offset      (i_offset),
        .i_job_index   (i_job_index),
        .i_exec_time   (i_exec_time),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_q_data      (q_wdata)
    );

    tsr_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    tsr_ram #(
        .WIDTH (LEN_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tsr_back #(
        .NUM_SLOTS (NUM_SLOTS),
        .QW        (QW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_slot_length (r_slot_length),
        .o_status      (status),
        .i_q_valid     (q_valid),
        .i_q_data      (q_rdata),
        .o_q_pop       (q_pop),
        .o_ram_we      (ram_we),
        .o_ram_waddr   (ram_waddr),
        .o_ram_wdata   (ram_wdata),
        .o_ram_raddr   (ram_raddr),
        .i_ram_rdata   (ram_rdata),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_start_time  (o_start_time),
        .o_end_time    (o_end_time),
        .o_overflow    (o_overflow)
    );

endmodule

`default_nettype wire
